// ===== design/ic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants for the inversion counter
// Defaults for the top-level parameters, fixed port widths, the controller
// state type and the command and status bundles.
// ----------------------------------------------------------------------------
package ic_pkg;

   // Parameter defaults
   localparam int MAX_ELEMS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 16;

   // Fixed field widths on the ports
   localparam int IN_VALUE_BITS = 16;
   localparam int TOTAL_BITS    = 11;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ic_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // take the request, store its element
      logic rd_issue;   // read the next stored element
      logic finish;     // close out the request
   } ic_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;       // store holds the maximum number of elements
      logic empty;      // no element stored yet in this sequence
      logic scan_last;  // the read being issued is the last stored element
   } ic_status_type;

endpackage : ic_pkg
`default_nettype wire

// ===== design/ic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_ctrl: inversion counter controller
// Sequences one request: accept, scan of the stored elements, pipeline
// drain and finish.
// ----------------------------------------------------------------------------
module ic_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ic_pkg::ic_status_type status,
   output ic_pkg::ic_cmd_type         cmd
);
   import ic_pkg::*;

   ic_state_type state_ff;
   ic_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               // nothing to compare against, or element dropped
               if (status.full || status.empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read data is compared in this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
      endcase
   end

   // Assertions
   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!status.empty && !status.full))
      else $error("scan with empty or full store");

   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(state_ff == ST_SCAN))
      else $error("drain not preceded by scan");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (!busy && start))
      else $error("accept while busy");

endmodule : ic_ctrl
`default_nettype wire

// ===== design/ic_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ic_dpath: inversion counter datapath
// Element memory, count, running total, overflow flag and the one-read-
// per-cycle compare pipeline.
// ----------------------------------------------------------------------------
module ic_dpath #(
   parameter int MAX_ELEMS  = ic_pkg::MAX_ELEMS_DEF,
   parameter int VALUE_BITS = ic_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [ic_pkg::IN_VALUE_BITS-1:0]  req_value,
   input  wire logic                              req_last,
   input  wire ic_pkg::ic_cmd_type                cmd,
   output ic_pkg::ic_status_type                  status,
   output logic                                   rsp_valid,
   output logic [ic_pkg::TOTAL_BITS-1:0]          rsp_inversions,
   output logic                                   rsp_overflow
);
   import ic_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_ELEMS);
   localparam int CNT_BITS = $clog2(MAX_ELEMS + 1);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_ELEMS);

   // Element store, no reset
   logic [VALUE_BITS-1:0] mem [MAX_ELEMS];
   logic [VALUE_BITS-1:0] mem_q_ff;

   // Request payload
   logic [VALUE_BITS+IN_VALUE_BITS-1:0] value_wide;
   logic [VALUE_BITS-1:0]               value_masked;
   logic [VALUE_BITS-1:0]               value_ff;
   logic                                last_ff;

   // Control registers
   logic [CNT_BITS-1:0]   count_ff,     count_in;
   logic [TOTAL_BITS-1:0] total_ff,     total_in;
   logic                  ovf_ff,       ovf_in;
   logic [IDX_BITS-1:0]   scan_idx_ff,  scan_idx_in;
   logic                  pend_ff,      pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Response payload
   logic [TOTAL_BITS-1:0] rsp_inv_ff;
   logic                  rsp_ovf_ff;

   // Keep the low VALUE_BITS of the request value
   assign value_wide   = {{VALUE_BITS{1'b0}}, req_value};
   assign value_masked = value_wide[VALUE_BITS-1:0];

   // Status
   assign status.full      = (count_ff == CNT_MAX);
   assign status.empty     = (count_ff == '0);
   assign status.scan_last = ((CNT_BITS'(scan_idx_ff) + CNT_BITS'(1)) == count_ff);

   // Memory write on accept, registered read during scan
   always_ff @(posedge clock) begin
      if (cmd.accept && !status.full) begin
         mem[count_ff[IDX_BITS-1:0]] <= value_masked;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= mem[scan_idx_ff];
      end
   end

   // Payload capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff <= value_masked;
         last_ff  <= req_last;
      end
      if (cmd.finish) begin
         rsp_inv_ff <= total_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   // Next values of the control registers
   always_comb begin
      count_in     = count_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = cmd.rd_issue;
      rsp_valid_in = 1'b0;

      // accept or advance the read pointer
      if (cmd.accept) begin
         scan_idx_in = '0;
         if (status.full) begin
            ovf_in = 1'b1;
         end
      end else if (cmd.rd_issue) begin
         scan_idx_in = scan_idx_ff + IDX_BITS'(1);
      end

      // stored element greater than the new one: saturating increment
      if (pend_ff && (mem_q_ff > value_ff) && (total_ff != TOTAL_MAX)) begin
         total_in = total_ff + TOTAL_BITS'(1);
      end

      // close out: respond and clear on last, else count the stored element
      if (cmd.finish) begin
         if (last_ff) begin
            rsp_valid_in = 1'b1;
            count_in     = '0;
            total_in     = '0;
            ovf_in       = 1'b0;
         end else if (!status.full) begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inversions = rsp_inv_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("element count beyond capacity");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd.finish)) |-> (total_ff >= $past(total_ff)))
      else $error("running total dropped without finish");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

   a_rsp_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff == '0 && total_ff == '0 && !ovf_ff))
      else $error("state not cleared after last request");

endmodule : ic_dpath
`default_nettype wire

// ===== design/inversion_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inversion_counter: counts strictly decreasing pairs in a sequence
// Usage:
//   Drive req_value and req_last with start high; the request is taken at a
//   rising edge where start is high and busy is low. One request carries one
//   element. The element is compared against every element already stored
//   in the current sequence through a single memory read port, one stored
//   element per cycle, and then stored.
//   With n elements already stored (0 < n < MAX_ELEMS), busy stays high
//   after the accepting edge through the scan of all n, the pipeline drain
//   and the finish; with none stored, or with the store full, only through
//   the finish.
//   On the request marked req_last, rsp_valid pulses for one cycle together
//   with rsp_inversions and rsp_overflow, in the first cycle busy is low;
//   the count, total and overflow flag then clear for the next sequence.
//   Elements beyond MAX_ELEMS are dropped and set the overflow flag.
//   The receiver cannot stall: each response is shown exactly once.
//   Synchronous reset clears the counters and the controller; the element
//   memory needs no clearing since only elements of the current sequence
//   are read.
// ----------------------------------------------------------------------------
module inversion_counter #(
   parameter int MAX_ELEMS  = ic_pkg::MAX_ELEMS_DEF,
   parameter int VALUE_BITS = ic_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ic_pkg::IN_VALUE_BITS-1:0]  req_value,
   input  wire logic                              req_last,
   output logic                                   rsp_valid,
   output logic [ic_pkg::TOTAL_BITS-1:0]          rsp_inversions,
   output logic                                   rsp_overflow
);
   import ic_pkg::*;

   ic_cmd_type    cmd;
   ic_status_type status;

   // Controller
   ic_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath
   ic_dpath #(
      .MAX_ELEMS  (MAX_ELEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_last       (req_last),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_inversions (rsp_inversions),
      .rsp_overflow   (rsp_overflow)
   );

endmodule : inversion_counter
`default_nettype wire
